[rtl/modexp_pkg.sv]
package modexp_pkg;
	// Configuration register indexes.
	localparam logic [0:0] REG_EXPONENT = 1'b0;
	localparam logic [0:0] REG_MODULUS  = 1'b1;
	localparam int unsigned CFG_INDEX_BITS = 1;
endpackage

[rtl/modexp_if.sv]
interface modexp_if #(
	parameter int unsigned WIDTH = 63
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/modexp_cfg_if.sv]
interface modexp_cfg_if #(
	parameter int unsigned WIDTH = 63
);
	logic                                valid;
	logic                                ready;
	logic [modexp_pkg::CFG_INDEX_BITS-1:0] index;
	logic [WIDTH-1:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/modular_exponentiation.sv]
// Modular exponentiation, right-to-left square-and-multiply. Each message
// request returns message^exponent mod modulus; a zero exponent returns 1 and
// a zero modulus returns 0. One message is worked at a time. The message is
// first reduced by the modulus. A bit-serial modular multiplier then doubles
// and adds once per cycle, and after its scan the ST_SQR state stores the
// product. Each exponent bit costs a square, and a set bit costs a multiply
// as well. A zero exponent or a zero modulus skips the work and goes straight
// to the done state. The result sits in an output register, and the next
// message can be taken while it waits. A finished result waits in the last
// state only while an earlier result is still held. Configuration writes are
// taken only while the block is idle. A message is not taken in a cycle that
// offers a write.
module modular_exponentiation #(
	parameter int unsigned OPERAND_BITS = 63
) (
	input logic clk,
	input logic arst_n,
	modexp_cfg_if.sink cfg,
	modexp_if.sink     message,
	modexp_if.source   result
);
	import modexp_pkg::*;

	localparam int unsigned CNT_BITS = $clog2(OPERAND_BITS + 1);
	localparam int unsigned W = OPERAND_BITS;

	typedef enum logic [2:0] {
		ST_IDLE, ST_REDUCE, ST_MUL, ST_SQR, ST_NEXT, ST_DONE
	} state_t;

	state_t              state_q;
	logic [W-1:0]        exp_reg_q, mod_reg_q;
	logic [W-1:0]        e_q, sq_q, acc_q, a_q, b_q, p_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [W-1:0]        res_q;
	logic                res_valid_q;
	logic                mul_is_acc_q;
	logic                res_load;

	// One step of the serial product: p = 2p + b_bit*a, each reduced.
	logic [W:0] dbl, dbl_r, add, add_r;
	always_comb begin
		dbl   = {p_q, 1'b0};
		dbl_r = (dbl >= {1'b0, mod_reg_q}) ? dbl - {1'b0, mod_reg_q} : dbl;
		add   = dbl_r + {1'b0, a_q};
		add_r = (add >= {1'b0, mod_reg_q}) ? add - {1'b0, mod_reg_q} : add;
	end

	// Reduction of the message: shift it in MSB first, doubling a remainder.
	logic [W:0] red, red_r;
	always_comb begin
		red   = {p_q, b_q[W-1]};
		red_r = (red >= {1'b0, mod_reg_q}) ? red - {1'b0, mod_reg_q} : red;
	end

	// A finished result moves to the output register once that register is free.
	assign res_load = (state_q == ST_DONE) && (!res_valid_q || result.ready);

	assign cfg.ready     = (state_q == ST_IDLE);
	assign message.ready = (state_q == ST_IDLE) && !cfg.valid;
	assign result.valid  = res_valid_q;
	assign result.data   = res_q;

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			exp_reg_q    <= '0;
			mod_reg_q    <= W'(1);
			res_valid_q  <= 1'b0;
			cnt_q        <= '0;
			mul_is_acc_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg.valid) begin
						if (cfg.index == REG_EXPONENT) begin
							exp_reg_q <= cfg.data;
						end else if (cfg.index == REG_MODULUS) begin
							mod_reg_q <= cfg.data;
						end
					end else if (message.valid) begin
						if (exp_reg_q == '0) begin
							acc_q   <= W'(1);
							state_q <= ST_DONE;
						end else if (mod_reg_q == '0) begin
							acc_q   <= '0;
							state_q <= ST_DONE;
						end else begin
							e_q     <= exp_reg_q;
							b_q     <= message.data;
							p_q     <= '0;
							cnt_q   <= CNT_BITS'(W);
							state_q <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE: begin
					p_q   <= red_r[W-1:0];
					b_q   <= {b_q[W-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_BITS'(1)) begin
						sq_q    <= red_r[W-1:0];
						// 1 mod m is 0 only for a modulus of one.
						acc_q   <= (mod_reg_q == W'(1)) ? '0 : W'(1);
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					p_q   <= '0;
					cnt_q <= CNT_BITS'(W);
					if (e_q == '0) begin
						state_q <= ST_DONE;
					end else if (e_q[0]) begin
						a_q          <= acc_q;
						b_q          <= sq_q;
						mul_is_acc_q <= 1'b1;
						state_q      <= ST_MUL;
					end else begin
						a_q          <= sq_q;
						b_q          <= sq_q;
						mul_is_acc_q <= 1'b0;
						state_q      <= ST_MUL;
					end
				end
				ST_MUL: begin
					p_q   <= b_q[W-1] ? add_r[W-1:0] : dbl_r[W-1:0];
					b_q   <= {b_q[W-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_BITS'(1)) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					// Store the finished product; after the multiply into acc, queue the square.
					p_q   <= '0;
					cnt_q <= CNT_BITS'(W);
					if (mul_is_acc_q) begin
						acc_q        <= p_q;
						a_q          <= sq_q;
						b_q          <= sq_q;
						mul_is_acc_q <= 1'b0;
						state_q      <= ST_MUL;
					end else begin
						sq_q    <= p_q;
						e_q     <= {1'b0, e_q[W-1:1]};
						state_q <= ST_NEXT;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						res_q   <= acc_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// A result is never overwritten while it waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.data))
		else $error("pending result lost");
	// No message is taken while work is under way.
	assert property (@(posedge clk) disable iff (!arst_n)
		message.ready |-> state_q == ST_IDLE)
		else $error("message accepted while busy");
	// The running values stay reduced during the scan.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> p_q < mod_reg_q && a_q < mod_reg_q)
		else $error("operand not reduced");
`endif
endmodule
